>>> design/k_nearest_to_origin_select_core_defines.svh
// assertion macros used by the core design file
`ifndef K_NEAREST_TO_ORIGIN_SELECT_CORE_DEFINES_SVH
`define K_NEAREST_TO_ORIGIN_SELECT_CORE_DEFINES_SVH

// consequence must hold in the same cycle
`define KNOS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequence must hold in the next cycle
`define KNOS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/knos_pkg.sv
package knos_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_COORD_BITS = 16;

	localparam int KEEP_BITS      = 5;
	localparam int APB_DATA_BITS  = 32;
	localparam int APB_ADDR_BITS  = 3;

	localparam logic [KEEP_BITS-1:0] KEEP_RESET = 5'd1;

	// register index, taken from paddr above the byte offset
	localparam logic [0:0] REG_KEEP_COUNT = 1'b0;

	typedef struct packed {
		logic ins;
		logic valid;
	} cell_ctl_t;

endpackage

>>> design/knos_if.sv
interface knos_point_if import knos_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] x_coord;
	logic signed [COORD_BITS-1:0] y_coord;
	logic                         final_point;

	modport source (output valid, output x_coord, output y_coord, output final_point,
		input ready);
	modport sink (input valid, input x_coord, input y_coord, input final_point,
		output ready);
endinterface

interface knos_near_if import knos_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] near_x;
	logic signed [COORD_BITS-1:0] near_y;
	logic                         run_end;

	modport source (output valid, output near_x, output near_y, output run_end,
		input ready);
	modport sink (input valid, input near_x, input near_y, input run_end,
		output ready);
endinterface

>>> design/knos_cfg.sv
module knos_cfg import knos_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output logic [KEEP_BITS-1:0]     keep_count
);
	logic [KEEP_BITS-1:0] keep_q;
	logic                 sel_keep;

	assign sel_keep   = (paddr[APB_ADDR_BITS-1:2] == REG_KEEP_COUNT);
	assign pready     = 1'b1;
	assign keep_count = keep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
		end else if (psel && penable && pwrite && sel_keep) begin
			keep_q <= pwdata[KEEP_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_keep) begin
			prdata = {{(APB_DATA_BITS-KEEP_BITS){1'b0}}, keep_q};
		end
	end

endmodule

>>> design/knos_cell.sv
module knos_cell import knos_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int DIST_BITS  = 2 * DEF_COORD_BITS
) (
	input  logic                         clk,
	input  cell_ctl_t                    ctl,
	input  logic [DIST_BITS-1:0]         new_d,
	input  logic signed [COORD_BITS-1:0] new_x,
	input  logic signed [COORD_BITS-1:0] new_y,
	input  logic                         prev_less,
	input  logic [DIST_BITS-1:0]         prev_d,
	input  logic signed [COORD_BITS-1:0] prev_x,
	input  logic signed [COORD_BITS-1:0] prev_y,
	output logic                         less,
	output logic [DIST_BITS-1:0]         ent_d,
	output logic signed [COORD_BITS-1:0] ent_x,
	output logic signed [COORD_BITS-1:0] ent_y
);
	logic [DIST_BITS-1:0]         d_q;
	logic signed [COORD_BITS-1:0] x_q;
	logic signed [COORD_BITS-1:0] y_q;
	logic                         lt;

	// key order: distance, then x, then y
	always_comb begin
		if (new_d != d_q) begin
			lt = (new_d < d_q);
		end else if (new_x != x_q) begin
			lt = (new_x < x_q);
		end else begin
			lt = (new_y < y_q);
		end
	end

	assign less  = ctl.valid && lt;
	assign ent_d = d_q;
	assign ent_x = x_q;
	assign ent_y = y_q;

	// shift down from the neighbor, or take the new point at its slot
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (prev_less) begin
				d_q <= prev_d;
				x_q <= prev_x;
				y_q <= prev_y;
			end else if (less || !ctl.valid) begin
				d_q <= new_d;
				x_q <= new_x;
				y_q <= new_y;
			end
		end
	end

endmodule

>>> design/k_nearest_to_origin_select_core.sv
// k nearest points to the origin.
// points (sink): one request per point, x_coord/y_coord signed, final_point
// closes a set. nearest (source): the kept points of a set, farthest first,
// run_end set on the nearest one. The user writes keep_count over the APB
// port (byte address 0) only while the block is idle, which the block does
// not enforce; values above CAPACITY act as CAPACITY, zero keeps nothing
// and a set then gives no result. A point is taken every cycle while the
// input is not held. Each point passes a squaring stage and an adding
// stage, then enters the row of CAPACITY cells, which insert it in key
// order. After a final point the input is held until all kept points have
// moved to the output register; results then leave one per cycle while
// the receiver takes them.
// A stalled receiver holds the output register and stops the read-out; the
// next set's points are accepted again once the last result has been loaded.
// Reset empties the list, sets keep_count to 1 and clears valid and hold.
module k_nearest_to_origin_select_core import knos_pkg::*; #(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	knos_point_if.sink               points,
	knos_near_if.source              nearest,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);
	`include "k_nearest_to_origin_select_core_defines.svh"

	localparam int DIST_BITS = 2 * COORD_BITS;
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_BITS  = (CNT_BITS > KEEP_BITS) ? CNT_BITS : KEEP_BITS;

	logic [KEEP_BITS-1:0] keep_count;
	logic [CNT_BITS-1:0]  k_eff;

	logic                         in_acc;
	logic signed [DIST_BITS-1:0]  sqx_c;
	logic signed [DIST_BITS-1:0]  sqy_c;

	logic                         valid_s1;
	logic                         last_s1;
	logic signed [COORD_BITS-1:0] x_s1;
	logic signed [COORD_BITS-1:0] y_s1;
	logic [DIST_BITS-1:0]         sqx_s1;
	logic [DIST_BITS-1:0]         sqy_s1;

	logic                         valid_s2;
	logic                         last_s2;
	logic signed [COORD_BITS-1:0] x_s2;
	logic signed [COORD_BITS-1:0] y_s2;
	logic [DIST_BITS-1:0]         dist_s2;

	logic [CNT_BITS-1:0] fill_q;
	logic [CNT_BITS:0]   fill_inc;
	logic [CNT_BITS-1:0] new_fill;
	logic [CNT_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0] cnt_dec;
	logic [IDX_BITS-1:0] rd_idx;
	logic                hold_q;
	logic                out_load;

	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] near_x_q;
	logic signed [COORD_BITS-1:0] near_y_q;
	logic                         run_end_q;

	logic [DIST_BITS-1:0]         ent_d [CAPACITY];
	logic signed [COORD_BITS-1:0] ent_x [CAPACITY];
	logic signed [COORD_BITS-1:0] ent_y [CAPACITY];
	logic                         less_w [CAPACITY];

	knos_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.keep_count (keep_count)
	);

	always_comb begin
		if (CMP_BITS'(keep_count) > CMP_BITS'(CAPACITY)) begin
			k_eff = CNT_BITS'(CAPACITY);
		end else begin
			k_eff = CNT_BITS'(keep_count);
		end
	end

	assign points.ready = !hold_q;
	assign in_acc       = points.valid && !hold_q;

	assign sqx_c = points.x_coord * points.x_coord;
	assign sqy_c = points.y_coord * points.y_coord;

	always_ff @(posedge clk) begin
		x_s1    <= points.x_coord;
		y_s1    <= points.y_coord;
		last_s1 <= points.final_point;
		sqx_s1  <= sqx_c;
		sqy_s1  <= sqy_c;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		last_s2 <= last_s1;
		dist_s2 <= sqx_s1 + sqy_s1;
	end

	// row of insertion cells, nearest at cell 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.ins   = valid_s2;
		assign ctl.valid = (fill_q > CNT_BITS'(i));

		if (i == 0) begin : g_head
			knos_cell #(.COORD_BITS(COORD_BITS), .DIST_BITS(DIST_BITS)) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.new_d     (dist_s2),
				.new_x     (x_s2),
				.new_y     (y_s2),
				.prev_less (1'b0),
				.prev_d    ({DIST_BITS{1'b0}}),
				.prev_x    ({COORD_BITS{1'b0}}),
				.prev_y    ({COORD_BITS{1'b0}}),
				.less      (less_w[i]),
				.ent_d     (ent_d[i]),
				.ent_x     (ent_x[i]),
				.ent_y     (ent_y[i])
			);
		end else begin : g_body
			knos_cell #(.COORD_BITS(COORD_BITS), .DIST_BITS(DIST_BITS)) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.new_d     (dist_s2),
				.new_x     (x_s2),
				.new_y     (y_s2),
				.prev_less (less_w[i-1]),
				.prev_d    (ent_d[i-1]),
				.prev_x    (ent_x[i-1]),
				.prev_y    (ent_y[i-1]),
				.less      (less_w[i]),
				.ent_d     (ent_d[i]),
				.ent_x     (ent_x[i]),
				.ent_y     (ent_y[i])
			);
		end
	end

	assign fill_inc = {1'b0, fill_q} + 1'b1;

	always_comb begin
		if (fill_inc > {1'b0, k_eff}) begin
			new_fill = k_eff;
		end else begin
			new_fill = fill_inc[CNT_BITS-1:0];
		end
	end

	assign cnt_dec  = cnt_q - 1'b1;
	assign rd_idx   = cnt_dec[IDX_BITS-1:0];
	assign out_load = (cnt_q != '0) && (!out_valid_q || nearest.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			fill_q      <= '0;
			cnt_q       <= '0;
			hold_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			valid_s2 <= valid_s1;

			if (valid_s2) begin
				fill_q <= last_s2 ? '0 : new_fill;
			end

			if (valid_s2 && last_s2) begin
				cnt_q <= new_fill;
			end else if (out_load) begin
				cnt_q <= cnt_dec;
			end

			if (in_acc && points.final_point) begin
				hold_q <= 1'b1;
			end else if ((valid_s2 && last_s2 && new_fill == '0) ||
				(out_load && cnt_q == CNT_BITS'(1))) begin
				hold_q <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (nearest.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			near_x_q  <= ent_x[rd_idx];
			near_y_q  <= ent_y[rd_idx];
			run_end_q <= (cnt_q == CNT_BITS'(1));
		end
	end

	assign nearest.valid   = out_valid_q;
	assign nearest.near_x  = near_x_q;
	assign nearest.near_y  = near_y_q;
	assign nearest.run_end = run_end_q;

	`KNOS_ASSERT_SAME(a_fill_cap, 1'b1, fill_q <= CNT_BITS'(CAPACITY), "fill above capacity")
	`KNOS_ASSERT_SAME(a_drain_holds, cnt_q != '0, hold_q, "read-out with input open")
	`KNOS_ASSERT_SAME(a_final_holds, valid_s2 && last_s2, hold_q && cnt_q == '0, "final point not held")
	`KNOS_ASSERT_NEXT(a_last_out, out_load && cnt_q == CNT_BITS'(1), !hold_q && nearest.run_end, "run end missing")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import knos_pkg::*;

	localparam int CAP = DEF_CAPACITY;
	localparam int CW = DEF_COORD_BITS;
	localparam int TOTAL_POINTS = 430;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT = 2000;
	localparam logic [APB_ADDR_BITS-1:0] KEEP_ADDR = {REG_KEEP_COUNT, 2'b00};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 last;
	} point_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 run_end;
	} near_t;

	typedef enum int {SPREAD_FULL, SPREAD_TINY, SPREAD_NEAR, SPREAD_EDGE} spread_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	knos_point_if #(.COORD_BITS(CW)) pt_if ();
	knos_near_if #(.COORD_BITS(CW)) near_if ();

	k_nearest_to_origin_select_core #(
		.CAPACITY(CAP),
		.COORD_BITS(CW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(pt_if),
		.nearest(near_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	point_t   point_q[$];
	near_t    near_expect_q[$];
	point_t   pt_cur = '0;
	logic     pt_valid = 1'b0;
	logic     pt_taken = 1'b0;
	logic     rx_ready = 1'b0;
	int       burst_left = 0;
	int       gap_left = 0;
	rx_mode_t rx_mode = RX_OPEN;
	logic [7:0] rx_pattern = 8'hff;
	int       rx_left = 0;
	int       fail_count = 0;
	int       quiet_cycles = 0;
	int       queued_total = 0;

	longint               kept_dist [0:CAP];
	logic signed [CW-1:0] kept_x [0:CAP];
	logic signed [CW-1:0] kept_y [0:CAP];
	int                   kept_fill = 0;
	logic [KEEP_BITS-1:0] keep_cfg = KEEP_RESET;

	assign pt_if.valid = pt_valid;
	assign pt_if.x_coord = pt_cur.x;
	assign pt_if.y_coord = pt_cur.y;
	assign pt_if.final_point = pt_cur.last;
	assign near_if.ready = rx_ready;

	always #1 clk = ~clk;

	function automatic bit key_below(input longint d, input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y, input int i);
		if (d != kept_dist[i])
			return d < kept_dist[i];
		if (x != kept_x[i])
			return x < kept_x[i];
		return y < kept_y[i];
	endfunction

	task automatic add_point(input point_t p);
		longint xl, yl, d;
		int k, pos;
		near_t r;
		xl = p.x;
		yl = p.y;
		d = xl * xl + yl * yl;
		k = (keep_cfg > CAP) ? CAP : int'(keep_cfg);
		pos = kept_fill;
		while (pos > 0 && key_below(d, p.x, p.y, pos - 1))
			pos--;
		for (int i = kept_fill; i > pos; i--) begin
			kept_dist[i] = kept_dist[i-1];
			kept_x[i] = kept_x[i-1];
			kept_y[i] = kept_y[i-1];
		end
		kept_dist[pos] = d;
		kept_x[pos] = p.x;
		kept_y[pos] = p.y;
		kept_fill++;
		if (kept_fill > k)
			kept_fill = k;
		if (p.last) begin
			for (int i = kept_fill; i > 0; i--) begin
				r.x = kept_x[i-1];
				r.y = kept_y[i-1];
				r.run_end = (i == 1);
				near_expect_q = {near_expect_q, r};
			end
			kept_fill = 0;
		end
	endtask

	// result check, request tracking and watchdog
	always @(posedge clk) begin : mon
		near_t got, exp;
		if (arst_n) begin
			pt_taken <= pt_valid && pt_if.ready;
			if (near_if.valid && rx_ready) begin
				got.x = near_if.near_x;
				got.y = near_if.near_y;
				got.run_end = near_if.run_end;
				if (near_expect_q.size() == 0) begin
					$display("%0t: unexpected result x=%0d y=%0d end=%0b", $time,
						got.x, got.y, got.run_end);
					fail_count++;
				end else begin
					exp = near_expect_q.pop_front();
					if (got !== exp) begin
						$display("%0t: mismatch expected x=%0d y=%0d end=%0b, got x=%0d y=%0d end=%0b",
							$time, exp.x, exp.y, exp.run_end, got.x, got.y, got.run_end);
						fail_count++;
					end
				end
			end
			if (pt_valid && pt_if.ready)
				add_point(pt_cur);
			if ((pt_valid && pt_if.ready) || (near_if.valid && rx_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout, %0d results still expected", $time, near_expect_q.size());
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic int pick_gap();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 0;
			5, 6, 7: return $urandom_range(1, 3);
			default: return $urandom_range(4, 12);
		endcase
	endfunction

	always @(negedge clk) begin : drv
		point_t nxt;
		logic nv;
		if (arst_n && (!pt_valid || pt_taken)) begin
			nv = 1'b0;
			nxt = pt_cur;
			if (gap_left > 0) begin
				gap_left--;
			end else if (point_q.size() != 0) begin
				nxt = point_q.pop_front();
				nv = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 32);
					gap_left = pick_gap();
				end
			end
			pt_valid <= nv;
			pt_cur <= nxt;
		end
	end

	always @(negedge clk) begin : rcv
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_pattern = 8'($urandom_range(1, 255));
			rx_left = $urandom_range(16, 96);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: rx_ready <= 1'b1;
			RX_COIN: rx_ready <= 1'($urandom_range(0, 1));
			RX_MOSTLY: rx_ready <= ($urandom_range(0, 3) != 0);
			default: begin
				rx_ready <= rx_pattern[0];
				rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
			end
		endcase
	end

	task automatic queue_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
		input logic last);
		point_t p;
		p.x = x;
		p.y = y;
		p.last = last;
		point_q = {point_q, p};
		queued_total++;
	endtask

	task automatic wait_idle(input int settle);
		while (point_q.size() != 0 || pt_valid || near_expect_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_keep_count(input logic [KEEP_BITS-1:0] value);
		logic [31:0] upper;
		upper = $urandom;
		wait_idle(SETTLE_CYCLES);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= KEEP_ADDR;
		pwdata <= {upper[APB_DATA_BITS-1:KEEP_BITS], value};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		keep_cfg = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [KEEP_BITS-1:0] pick_keep();
		case ($urandom_range(0, 9))
			0: return KEEP_BITS'(0);
			1: return KEEP_BITS'(1);
			2: return KEEP_BITS'(CAP);
			3: return KEEP_BITS'($urandom_range(CAP + 1, 30));
			4: return KEEP_BITS'(31);
			default: return KEEP_BITS'($urandom_range(1, CAP));
		endcase
	endfunction

	function automatic logic signed [CW-1:0] pick_coord(input spread_t spread);
		logic [31:0] r;
		int v;
		r = $urandom;
		case (spread)
			SPREAD_FULL: return r[CW-1:0];
			SPREAD_TINY: v = $urandom_range(0, 8) - 4;
			SPREAD_NEAR: v = $urandom_range(0, 600) - 300;
			default: begin
				case ($urandom_range(0, 6))
					0: v = -32768;
					1: v = -32767;
					2: v = -1;
					3: v = 0;
					4: v = 1;
					5: v = 32766;
					default: v = 32767;
				endcase
			end
		endcase
		return v[CW-1:0];
	endfunction

	initial begin : stim
		int len, split;
		spread_t spread;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// keep count still at its reset value
		queue_point(16'sd32767, 16'sd32767, 1'b0);
		queue_point(-16'sd32768, -16'sd32768, 1'b0);
		queue_point(16'sd0, 16'sd0, 1'b1);

		// ties on distance resolved by x then y, plus a duplicate
		set_keep_count(KEEP_BITS'(CAP));
		queue_point(16'sd3, 16'sd4, 1'b0);
		queue_point(16'sd4, 16'sd3, 1'b0);
		queue_point(-16'sd3, 16'sd4, 1'b0);
		queue_point(16'sd3, -16'sd4, 1'b0);
		queue_point(-16'sd4, -16'sd3, 1'b0);
		queue_point(16'sd5, 16'sd0, 1'b0);
		queue_point(16'sd0, -16'sd5, 1'b0);
		queue_point(16'sd3, 16'sd4, 1'b0);
		queue_point(-16'sd32768, 16'sd0, 1'b0);
		queue_point(16'sd0, 16'sd32767, 1'b0);
		queue_point(-16'sd1, -16'sd1, 1'b1);

		// nothing kept
		set_keep_count(KEEP_BITS'(0));
		queue_point(16'sd1, 16'sd2, 1'b0);
		queue_point(-16'sd5, 16'sd7, 1'b1);

		// count lowered in the middle of a set
		set_keep_count(KEEP_BITS'(3));
		queue_point(16'sd10, 16'sd10, 1'b0);
		queue_point(16'sd1, 16'sd1, 1'b0);
		queue_point(-16'sd7, 16'sd2, 1'b0);
		set_keep_count(KEEP_BITS'(2));
		queue_point(16'sd0, 16'sd3, 1'b1);

		// count above capacity
		set_keep_count(KEEP_BITS'(31));
		queue_point(16'sd2, 16'sd2, 1'b1);

		while (queued_total < TOTAL_POINTS) begin
			if ($urandom_range(0, 2) != 0)
				set_keep_count(pick_keep());
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 20);
			spread = spread_t'($urandom_range(0, 3));
			split = ($urandom_range(0, 4) == 0 && len > 1) ? $urandom_range(1, len - 1) : 0;
			for (int i = 0; i < len; i++) begin
				if (split != 0 && i == split)
					set_keep_count(pick_keep());
				queue_point(pick_coord(spread), pick_coord(spread), i == len - 1);
			end
		end

		wait_idle(DRAIN_CYCLES);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
